// ===== design/assert_macros.svh =====
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sppc_pkg.sv =====
// Package with the codes, widths and reset values of the sump pump charger controller.
`timescale 1ns / 1ps

package sppc_pkg;

	typedef enum logic [2:0] {
		FUNC_LEVEL  = 3'd0,
		FUNC_VOLT   = 3'd1,
		FUNC_SWITCH = 3'd2,
		FUNC_DASH   = 3'd3,
		FUNC_TICK   = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		CFG_SUMP_DEPTH  = 3'd0,
		CFG_HIGH_LIMIT  = 3'd1,
		CFG_LOW_LIMIT   = 3'd2,
		CFG_CUT_IN      = 3'd3,
		CFG_CUT_OUT     = 3'd4,
		CFG_MAX_CHARGE  = 3'd5,
		CFG_CONFIDENCE  = 3'd6,
		CFG_FLASH       = 3'd7
	} cfg_index_t;

	localparam int MmW    = 13;
	localparam int MvW    = 15;
	localparam int LevelW = 15;
	localparam int OutLvW = 14;
	localparam int CountW = 16;
	localparam int TimeW  = 32;

	localparam logic [MmW-1:0]    SumpDepthRst  = 13'd1000;
	localparam logic [MmW-1:0]    HighLimitRst  = 13'd300;
	localparam logic [MmW-1:0]    LowLimitRst   = 13'd100;
	localparam logic [MvW-1:0]    CutInRst      = 15'd12000;
	localparam logic [MvW-1:0]    CutOutRst     = 15'd13800;
	localparam logic [TimeW-1:0]  MaxChargeRst  = 32'd3600000;
	localparam logic [CountW-1:0] ConfidenceRst = 16'd5;
	localparam logic [CountW-1:0] FlashRst      = 16'd500;

endpackage

// ===== design/sump_pump_charger_controller_core.sv =====
// Sump pump and battery charger controller: one registered pass per request.
//
// Usage:
//  Requests enter on the s_ group: s_tuser holds the kind (level sample,
//  voltage sample, physical switch, dashboard request, 1 ms tick) and s_tdata
//  the sample fields. Every request gives exactly one result on the m_ group,
//  carrying the drive outputs, the LED lamps, the manual flag and the water
//  level after that request.
//  The cfg_ group writes the eight setting registers; it is always ready and
//  is meant to be used while no request is in flight.
//  A request sits in the input register while the update logic computes the
//  next state, and the state flops, which drive the result directly, load
//  it when the previous result has been taken or there is none. Throughput
//  is one request per cycle while the receiver does not stall; the update
//  of the controller state is combinational compares and counter
//  increments, so a request can follow in the next cycle.
//  When the receiver stalls, the result and the state hold, one more request
//  waits in the input register, and s_tready drops after that.
//  Reset clears all state and outputs and loads the settings with defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sump_pump_charger_controller_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// [12:0] distance_mm, [13] distance_valid, [28:14] battery_mv, [29] switch_on
	input  logic [31:0]               s_tdata,
	// [2:0] func
	input  logic [2:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [0] pump_on, [1] charger_on, [2] green_led, [3] red_led, [4] manual_mode,
	// [18:5] water_level_mm
	output logic [23:0]               m_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  sppc_pkg::cfg_index_t      cfg_index,
	input  logic [31:0]               cfg_data
);
	import sppc_pkg::*;

	// Settings.
	logic [MmW-1:0]    sump_depth_q, high_limit_q, low_limit_q;
	logic [MvW-1:0]    cut_in_q, cut_out_q;
	logic [TimeW-1:0]  max_charge_q;
	logic [CountW-1:0] confidence_q, flash_period_q;

	// Input stage.
	logic              valid_s1;
	logic [2:0]        func_s1;
	logic [MmW-1:0]    dist_s1;
	logic              dist_valid_s1;
	logic [MvW-1:0]    mv_s1;
	logic              sw_s1;

	// Controller state; it also drives the result.
	logic signed [LevelW-1:0] water_level_q, water_level_d;
	logic              level_valid_q, level_valid_d;
	logic [CountW-1:0] level_count_q, level_count_d;
	logic [CountW-1:0] volt_count_q, volt_count_d;
	logic [MvW-1:0]    last_voltage_q, last_voltage_d;
	logic              phys_switch_q, phys_switch_d;
	logic              manual_q, manual_d;
	logic              first_tick_q, first_tick_d;
	logic              pump_q, pump_d;
	logic              charge_q, charge_d;
	logic              green_q, green_d;
	logic              red_q, red_d;
	logic [TimeW-1:0]  charge_elapsed_q, charge_elapsed_d;
	logic [CountW-1:0] flash_elapsed_q, flash_elapsed_d;
	logic              out_valid_q;

	logic              advance;
	logic signed [LevelW-1:0] new_level;
	logic              want_manual;
	logic              phys_after;
	logic              manual_after;
	logic [CountW-1:0] flash_inc;
	logic [TimeW-1:0]  charge_inc;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {5'd0, water_level_q[OutLvW-1:0], manual_q, red_q, green_q,
		charge_q, pump_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sump_depth_q   <= SumpDepthRst;
			high_limit_q   <= HighLimitRst;
			low_limit_q    <= LowLimitRst;
			cut_in_q       <= CutInRst;
			cut_out_q      <= CutOutRst;
			max_charge_q   <= MaxChargeRst;
			confidence_q   <= ConfidenceRst;
			flash_period_q <= FlashRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SUMP_DEPTH: sump_depth_q   <= cfg_data[MmW-1:0];
				CFG_HIGH_LIMIT: high_limit_q   <= cfg_data[MmW-1:0];
				CFG_LOW_LIMIT:  low_limit_q    <= cfg_data[MmW-1:0];
				CFG_CUT_IN:     cut_in_q       <= cfg_data[MvW-1:0];
				CFG_CUT_OUT:    cut_out_q      <= cfg_data[MvW-1:0];
				CFG_MAX_CHARGE: max_charge_q   <= cfg_data[TimeW-1:0];
				CFG_CONFIDENCE: confidence_q   <= cfg_data[CountW-1:0];
				CFG_FLASH:      flash_period_q <= cfg_data[CountW-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1       <= s_tuser;
			dist_s1       <= s_tdata[12:0];
			dist_valid_s1 <= s_tdata[13];
			mv_s1         <= s_tdata[28:14];
			sw_s1         <= s_tdata[29];
		end
	end

	assign new_level = $signed({2'b00, sump_depth_q}) - $signed({2'b00, dist_s1});
	assign flash_inc = (&flash_elapsed_q) ? flash_elapsed_q : flash_elapsed_q + 1'b1;
	assign charge_inc = (&charge_elapsed_q) ? charge_elapsed_q : charge_elapsed_q + 1'b1;

	always_comb begin
		water_level_d    = water_level_q;
		level_valid_d    = level_valid_q;
		level_count_d    = level_count_q;
		volt_count_d     = volt_count_q;
		last_voltage_d   = last_voltage_q;
		phys_switch_d    = phys_switch_q;
		manual_d         = manual_q;
		first_tick_d     = first_tick_q;
		pump_d           = pump_q;
		charge_d         = charge_q;
		green_d          = green_q;
		red_d            = red_q;
		charge_elapsed_d = charge_elapsed_q;
		flash_elapsed_d  = flash_elapsed_q;
		want_manual      = sw_s1;
		phys_after       = (func_s1 == FUNC_SWITCH) ? sw_s1 : phys_switch_q;
		manual_after     = want_manual ? 1'b1 : (phys_after ? manual_q : 1'b0);

		case (func_s1)
			FUNC_LEVEL: begin
				level_valid_d = dist_valid_s1;
				if (dist_valid_s1) begin
					water_level_d = new_level;
					if (new_level >= $signed({2'b00, high_limit_q})) begin
						if (!(&level_count_q))
							level_count_d = level_count_q + 1'b1;
					end else begin
						level_count_d = '0;
					end
				end else begin
					level_count_d = '0;
				end
			end
			FUNC_VOLT: begin
				last_voltage_d = mv_s1;
				if (mv_s1 <= cut_in_q) begin
					if (!(&volt_count_q))
						volt_count_d = volt_count_q + 1'b1;
				end else begin
					volt_count_d = '0;
				end
			end
			FUNC_SWITCH, FUNC_DASH: begin
				phys_switch_d = phys_after;
				manual_d      = manual_after;
				// Going into manual mode stops both drives.
				if (!manual_q && manual_after) begin
					pump_d   = 1'b0;
					charge_d = 1'b0;
				end
			end
			FUNC_TICK: begin
				// The very first tick takes the manual mode from the physical switch.
				if (!first_tick_q)
					manual_d = phys_switch_q;
				first_tick_d     = 1'b1;
				charge_elapsed_d = charge_inc;
				flash_elapsed_d  = flash_inc;
				if (flash_inc >= flash_period_q) begin
					flash_elapsed_d = '0;
					if (charge_q && pump_q) begin
						green_d = !green_q;
						red_d   = green_q;
					end else if (!manual_d) begin
						green_d = 1'b1;
						red_d   = charge_q ? 1'b1 : (pump_q ? !red_q : 1'b0);
					end else begin
						green_d = !green_q;
						red_d   = charge_q ? 1'b1 : (pump_q ? !green_q : 1'b0);
					end
				end
				if (!manual_d) begin
					if (!charge_q && !pump_q && volt_count_q >= confidence_q) begin
						charge_d         = 1'b1;
						volt_count_d     = '0;
						charge_elapsed_d = '0;
					end else if (last_voltage_q >= cut_out_q || charge_inc >= max_charge_q) begin
						charge_d = 1'b0;
					end
					if (!pump_q && level_count_q >= confidence_q) begin
						charge_d      = 1'b0;
						pump_d        = 1'b1;
						level_count_d = '0;
					end else if (pump_q && level_valid_q &&
							water_level_q <= $signed({2'b00, low_limit_q})) begin
						pump_d = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_level_q    <= '0;
			level_valid_q    <= 1'b0;
			level_count_q    <= '0;
			volt_count_q     <= '0;
			last_voltage_q   <= '0;
			phys_switch_q    <= 1'b0;
			manual_q         <= 1'b0;
			first_tick_q     <= 1'b0;
			pump_q           <= 1'b0;
			charge_q         <= 1'b0;
			green_q          <= 1'b0;
			red_q            <= 1'b0;
			charge_elapsed_q <= '0;
			flash_elapsed_q  <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (advance) begin
				water_level_q    <= water_level_d;
				level_valid_q    <= level_valid_d;
				level_count_q    <= level_count_d;
				volt_count_q     <= volt_count_d;
				last_voltage_q   <= last_voltage_d;
				phys_switch_q    <= phys_switch_d;
				manual_q         <= manual_d;
				first_tick_q     <= first_tick_d;
				pump_q           <= pump_d;
				charge_q         <= charge_d;
				green_q          <= green_d;
				red_q            <= red_d;
				charge_elapsed_q <= charge_elapsed_d;
				flash_elapsed_q  <= flash_elapsed_d;
				out_valid_q      <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_ALWAYS(a_drives_exclusive, clk, !(pump_q && charge_q), "pump and charger both on")

	`ASSERT_CLK(a_advance_gives_result, clk, arst_n, advance |=> out_valid_q,
		"processed request produced no result")

	`ASSERT_CLK(a_stall_holds_state, clk, arst_n,
		(out_valid_q && !m_tready) |=> ($stable(pump_q) && $stable(charge_q) &&
		$stable(level_count_q) && $stable(flash_elapsed_q)),
		"state changed while result was stalled")

	`ASSERT_CLK(a_manual_entry_stops, clk, arst_n,
		(advance && first_tick_q && !manual_q && manual_d) |=> (!pump_q && !charge_q),
		"drives left on when entering manual mode")

endmodule
